@@ rtl/core/mtep_pkg.sv @@
// ============================================================================
// mtep_pkg - shared types and constants for the MIDI track event parser
// Result item layout, item kinds, error codes and the meta length table.
// ============================================================================
package mtep_pkg;

    // Default longest variable-length quantity, in bytes
    localparam int VLQ_MAX_BYTES_DEF = 4;

    localparam int VLQ_W   = 28;  // decoded delta / length width
    localparam int CNT_W   = 3;   // byte counter width
    localparam int TAG_LEN = 4;   // chunk tag and chunk length size in bytes

    // Output tdata width, padded to whole bytes
    localparam int OUT_FIELDS_W = 28 + 8 + 8 + 8 + 8 + 28 + 8 + 2 + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Status and meta codes
    localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [3:0] STATUS_HI_SYSTEM  = 4'hF;
    localparam logic [3:0] STATUS_HI_PROGRAM = 4'hC;
    localparam logic [3:0] STATUS_HI_CHANPRS = 4'hD;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_BAD_TAG      = 2'd0,
        ERR_BAD_STATUS   = 2'd1,
        ERR_UNKNOWN_META = 2'd2,
        ERR_META_LENGTH  = 2'd3
    } t_err;

    // One result item, fields as they leave the block
    typedef struct packed {
        t_kind            kind;
        logic [VLQ_W-1:0] delta_ticks;
        logic [7:0]       status_byte;
        logic [7:0]       first_data;
        logic [7:0]       second_data;
        logic [7:0]       meta_kind;
        logic [VLQ_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             last;
        t_err             error_code;
        logic             track_end;
    } t_result;

    // Expected length of a meta event type
    typedef struct packed {
        logic       known;  // type is recognized
        logic       any;    // any length accepted
        logic [2:0] len;    // fixed length when not any
    } t_meta_len;

    function automatic t_meta_len meta_len_of(input logic [7:0] t);
        t_meta_len m;
        m = '{known: 1'b1, any: 1'b0, len: 3'd0};
        case (t)
            8'h00: m.len = 3'd2;
            8'h01, 8'h02, 8'h03, 8'h04,
            8'h05, 8'h06, 8'h07, 8'h7F: m.any = 1'b1;
            8'h20: m.len = 3'd1;
            8'h21: m.len = 3'd1;
            8'h2F: m.len = 3'd0;
            8'h51: m.len = 3'd3;
            8'h54: m.len = 3'd5;
            8'h58: m.len = 3'd4;
            8'h59: m.len = 3'd2;
            default: m.known = 1'b0;
        endcase
        return m;
    endfunction

    // Chunk tag "MTrk", one byte per position
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4D;
            2'd1:    v = 8'h54;
            2'd2:    v = 8'h72;
            default: v = 8'h6B;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/mtep_in_reg.sv @@
// ============================================================================
// mtep_in_reg - input register stage
// Captures one raw byte and its restart flag per transfer.
// ============================================================================
module mtep_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    output logic       o_valid,
    input  logic       i_take,
    output logic [7:0] o_byte,
    output logic       o_restart
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_restart;

    // Free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte    <= i_byte;
            r_restart <= i_restart;
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_restart = r_restart;

endmodule

@@ rtl/core/mtep_decoder.sv @@
// ============================================================================
// mtep_decoder - track chunk decode state machine
// Consumes one byte per step and produces at most one result item.
// ============================================================================
module mtep_decoder #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_restart,
    output logic              o_res_valid,
    output mtep_pkg::t_result o_res
);

    localparam int CW = mtep_pkg::CNT_W;
    localparam int VW = mtep_pkg::VLQ_W;

    typedef enum logic [3:0] {
        PH_TAG      = 4'd0,
        PH_LEN      = 4'd1,
        PH_DELTA    = 4'd2,
        PH_STATUS   = 4'd3,
        PH_DATA1    = 4'd4,
        PH_DATA2    = 4'd5,
        PH_SYSLEN   = 4'd6,
        PH_METATYPE = 4'd7,
        PH_METALEN  = 4'd8,
        PH_PAYLOAD  = 4'd9
    } t_phase;

    t_phase        r_phase,  n_phase,  e_phase;
    logic [CW-1:0] r_cnt,    n_cnt,    e_cnt;
    logic [VW-1:0] r_vlq,    n_vlq,    e_vlq;
    logic [7:0]    r_prev,   n_prev,   e_prev;
    logic [7:0]    r_cur,    n_cur,    e_cur;
    logic [7:0]    r_held,   n_held,   e_held;
    logic [7:0]    r_meta,   n_meta,   e_meta;
    logic [VW-1:0] r_delta,  n_delta,  e_delta;
    logic [VW-1:0] r_rem,    n_rem,    e_rem;
    logic          r_halt,   n_halt,   e_halt;

    logic [CW-1:0]       cnt_inc;
    logic [VW-1:0]       vlq_base;
    logic [VW-1:0]       vlq_nx;
    logic                vlq_done;
    logic [VW-1:0]       rem_dec;
    logic [7:0]          st;
    logic                running;
    logic                two_data;
    mtep_pkg::t_meta_len mlen;
    mtep_pkg::t_meta_len mlen_in;

    function automatic mtep_pkg::t_result make_record(
        input logic [VW-1:0] delta,
        input logic [7:0]    status,
        input logic [7:0]    d1,
        input logic [7:0]    d2,
        input logic [7:0]    meta,
        input logic [VW-1:0] plen,
        input logic          tend
    );
        mtep_pkg::t_result r;
        r                = '0;
        r.kind           = mtep_pkg::KIND_RECORD;
        r.delta_ticks    = delta;
        r.status_byte    = status;
        r.first_data     = d1;
        r.second_data    = d2;
        r.meta_kind      = meta;
        r.payload_length = plen;
        r.last           = (plen == '0);
        r.track_end      = tend;
        return r;
    endfunction

    function automatic mtep_pkg::t_result make_error(input mtep_pkg::t_err code);
        mtep_pkg::t_result r;
        r            = '0;
        r.kind       = mtep_pkg::KIND_ERROR;
        r.last       = 1'b1;
        r.error_code = code;
        return r;
    endfunction

    // Restart byte sees the reset state
    always_comb begin
        if (i_restart) begin
            e_phase = PH_TAG;
            e_cnt   = '0;
            e_vlq   = '0;
            e_prev  = '0;
            e_cur   = '0;
            e_held  = '0;
            e_meta  = '0;
            e_delta = '0;
            e_rem   = '0;
            e_halt  = 1'b0;
        end else begin
            e_phase = r_phase;
            e_cnt   = r_cnt;
            e_vlq   = r_vlq;
            e_prev  = r_prev;
            e_cur   = r_cur;
            e_held  = r_held;
            e_meta  = r_meta;
            e_delta = r_delta;
            e_rem   = r_rem;
            e_halt  = r_halt;
        end
    end

    // Shared datapath pieces
    assign cnt_inc  = e_cnt + CW'(1);
    assign vlq_base = (e_cnt == '0) ? '0 : e_vlq;
    assign vlq_nx   = {vlq_base[VW-8:0], i_byte[6:0]};
    assign vlq_done = !i_byte[7] || (cnt_inc >= CW'(VLQ_MAX_BYTES));
    assign rem_dec  = e_rem - VW'(1);
    assign running  = !i_byte[7];
    assign st       = running ? e_prev : i_byte;
    assign two_data = !(e_cur[7:4] inside {mtep_pkg::STATUS_HI_PROGRAM,
                                           mtep_pkg::STATUS_HI_CHANPRS});
    assign mlen     = mtep_pkg::meta_len_of(e_meta);
    assign mlen_in  = mtep_pkg::meta_len_of(i_byte);

    // Next state and result
    always_comb begin
        logic st_two;
        n_phase     = e_phase;
        n_cnt       = e_cnt;
        n_vlq       = e_vlq;
        n_prev      = e_prev;
        n_cur       = e_cur;
        n_held      = e_held;
        n_meta      = e_meta;
        n_delta     = e_delta;
        n_rem       = e_rem;
        n_halt      = e_halt;
        o_res       = '0;
        o_res_valid = 1'b0;
        st_two      = !(st[7:4] inside {mtep_pkg::STATUS_HI_PROGRAM,
                                        mtep_pkg::STATUS_HI_CHANPRS});

        if (!e_halt) begin
            case (e_phase)
                PH_TAG: begin
                    if (i_byte != mtep_pkg::tag_byte(e_cnt[1:0])) begin
                        o_res       = make_error(mtep_pkg::ERR_BAD_TAG);
                        o_res_valid = 1'b1;
                        n_halt      = 1'b1;
                    end else if (cnt_inc >= CW'(mtep_pkg::TAG_LEN)) begin
                        n_cnt   = '0;
                        n_phase = PH_LEN;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_LEN: begin
                    if (cnt_inc >= CW'(mtep_pkg::TAG_LEN)) begin
                        n_cnt   = '0;
                        n_phase = PH_DELTA;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_DELTA: begin
                    n_vlq = vlq_nx;
                    n_cnt = vlq_done ? '0 : cnt_inc;
                    if (vlq_done) begin
                        n_delta = vlq_nx;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_cur = st;
                    if (!st[7]) begin
                        o_res       = make_error(mtep_pkg::ERR_BAD_STATUS);
                        o_res_valid = 1'b1;
                        n_halt      = 1'b1;
                    end else if (st[7:4] == mtep_pkg::STATUS_HI_SYSTEM) begin
                        // system status cancels running status
                        n_prev = '0;
                        if (st == mtep_pkg::STATUS_SYSEX) begin
                            n_phase = PH_SYSLEN;
                        end else if (st == mtep_pkg::STATUS_META) begin
                            n_phase = PH_METATYPE;
                        end else begin
                            n_phase     = PH_DELTA;
                            o_res       = make_record(e_delta, st, '0, '0, '0, '0, 1'b0);
                            o_res_valid = 1'b1;
                        end
                    end else begin
                        n_prev = st;
                        if (!running) begin
                            n_phase = PH_DATA1;
                        end else begin
                            // running status: this byte is the first data byte
                            n_held = i_byte;
                            if (st_two) begin
                                n_phase = PH_DATA2;
                            end else begin
                                n_phase     = PH_DELTA;
                                o_res       = make_record(e_delta, st, i_byte, '0, '0, '0,
                                                          1'b0);
                                o_res_valid = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA1: begin
                    n_held = i_byte;
                    if (two_data) begin
                        n_phase = PH_DATA2;
                    end else begin
                        n_phase     = PH_DELTA;
                        o_res       = make_record(e_delta, e_cur, i_byte, '0, '0, '0, 1'b0);
                        o_res_valid = 1'b1;
                    end
                end
                PH_DATA2: begin
                    n_phase     = PH_DELTA;
                    o_res       = make_record(e_delta, e_cur, e_held, i_byte, '0, '0, 1'b0);
                    o_res_valid = 1'b1;
                end
                PH_SYSLEN: begin
                    n_rem       = VW'(i_byte);
                    n_phase     = (i_byte != '0) ? PH_PAYLOAD : PH_DELTA;
                    o_res       = make_record(e_delta, e_cur, '0, '0, '0, VW'(i_byte), 1'b0);
                    o_res_valid = 1'b1;
                end
                PH_METATYPE: begin
                    n_meta = i_byte;
                    if (!mlen_in.known) begin
                        o_res       = make_error(mtep_pkg::ERR_UNKNOWN_META);
                        o_res_valid = 1'b1;
                        n_halt      = 1'b1;
                    end else begin
                        n_cnt   = '0;
                        n_phase = PH_METALEN;
                    end
                end
                PH_METALEN: begin
                    n_vlq = vlq_nx;
                    n_cnt = vlq_done ? '0 : cnt_inc;
                    if (vlq_done) begin
                        if (!mlen.any && (vlq_nx != VW'(mlen.len))) begin
                            o_res       = make_error(mtep_pkg::ERR_META_LENGTH);
                            o_res_valid = 1'b1;
                            n_halt      = 1'b1;
                        end else begin
                            n_rem       = vlq_nx;
                            o_res_valid = 1'b1;
                            if (e_meta == mtep_pkg::META_END_OF_TRACK) begin
                                // end of track: next byte opens a new chunk
                                n_phase = PH_TAG;
                                o_res   = make_record(e_delta, e_cur, '0, '0, e_meta, '0,
                                                      1'b1);
                            end else begin
                                n_phase = (vlq_nx != '0) ? PH_PAYLOAD : PH_DELTA;
                                o_res   = make_record(e_delta, e_cur, '0, '0, e_meta,
                                                      vlq_nx, 1'b0);
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_rem              = rem_dec;
                    o_res.kind         = mtep_pkg::KIND_PAYLOAD;
                    o_res.payload_byte = i_byte;
                    o_res.last         = (rem_dec == '0);
                    o_res_valid        = 1'b1;
                    if (rem_dec == '0) begin
                        n_phase = PH_DELTA;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_cnt   <= '0;
            r_vlq   <= '0;
            r_prev  <= '0;
            r_cur   <= '0;
            r_held  <= '0;
            r_meta  <= '0;
            r_delta <= '0;
            r_rem   <= '0;
            r_halt  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_vlq   <= n_vlq;
            r_prev  <= n_prev;
            r_cur   <= n_cur;
            r_held  <= n_held;
            r_meta  <= n_meta;
            r_delta <= n_delta;
            r_rem   <= n_rem;
            r_halt  <= n_halt;
        end
    end

endmodule

@@ rtl/core/mtep_out_reg.sv @@
// ============================================================================
// mtep_out_reg - result register
// Holds one result item until the downstream transfer completes.
// ============================================================================
module mtep_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mtep_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output mtep_pkg::t_result o_res
);

    logic              r_valid;
    mtep_pkg::t_result r_res;

    // Room for a new item when empty or draining this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/core/midi_track_event_parser.sv @@
// ============================================================================
// midi_track_event_parser - Standard MIDI File track chunk parser
// Checks the chunk tag, skips the chunk length and decodes track events into
// event records, payload bytes and error items, one raw byte per transfer.
// ============================================================================
// An input byte passes the input register, the decoder and the result register.
// Throughput: one byte per cycle while the result register has room.
// Bytes that yield no result item produce no output transfer.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to the chunk tag; a byte with restart set first resets the decoder.
module midi_track_event_parser #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] in_byte
    input  logic                             s_axis_tuser,  // [0] restart
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [27:0] delta_ticks, [35:28] status_byte, [43:36] first_data,
    // [51:44] second_data, [59:52] meta_kind, [87:60] payload_length,
    // [95:88] payload_byte, [97:96] error_code, [98] track_end, rest zero
    output logic [mtep_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast   // last
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              in_restart;
    logic              out_free;
    logic              step;
    logic              res_valid;
    mtep_pkg::t_result res;
    mtep_pkg::t_result out_res;

    // Input register
    mtep_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_restart (s_axis_tuser),
        .o_valid   (in_valid),
        .i_take    (step),
        .o_byte    (in_byte),
        .o_restart (in_restart)
    );

    // A held byte is decoded once the result register has room
    assign step = in_valid && out_free;

    mtep_decoder #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .i_restart   (in_restart),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mtep_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Pack the result fields, delta_ticks in the lowest bits
    assign m_axis_tdata = {
        {(mtep_pkg::OUT_DATA_W - mtep_pkg::OUT_FIELDS_W){1'b0}},
        out_res.track_end,
        out_res.error_code,
        out_res.payload_byte,
        out_res.payload_length,
        out_res.meta_kind,
        out_res.second_data,
        out_res.first_data,
        out_res.status_byte,
        out_res.delta_ticks
    };
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

@@ rtl/core/mtep_checker.sv @@
// ============================================================================
// mtep_checker - port-level checks for the MIDI track event parser
// Watches the output stream for malformed items and stalls that lose data.
// ============================================================================
module mtep_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [7:0]                      s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mtep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00 || s_axis_tuser);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Error items close the event
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == mtep_pkg::KIND_ERROR |-> m_axis_tlast)
        else $error("error item without last");

    // A record with no payload is the final item of its event
    a_rec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == mtep_pkg::KIND_RECORD
            && m_axis_tdata[87:60] == '0 |-> m_axis_tlast)
        else $error("empty record without last");

    // End of track only on a record, and never with payload
    a_end_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[98] |->
            m_axis_tuser == mtep_pkg::KIND_RECORD && m_axis_tlast)
        else $error("track end on a non-final or non-record item");

    // Nothing arrives before the first input transfer after reset
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) && !in_xfer
            && !$past(m_axis_tvalid) |=> !m_axis_tvalid || $past(s_axis_tvalid))
        else $error("result without an input transfer");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench - MIDI track event parser
// Feeds raw track chunk bytes over the input stream and checks every output
// transfer field by field against a byte-level model of the parser. The
// stimulus is mostly well-formed tracks with random events, plus tag,
// status and meta errors, restarts and abandoned tracks. Both stream sides
// idle at random.
// ============================================================================
module testbench;
    import mtep_pkg::*;

    localparam int STALL_LIMIT = 500;  // cycles with no transfer on either side
    localparam int TARGET_ITEMS = 700;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] STATUS_TUNE_REQ = 8'hF6;

    typedef enum logic [3:0] {
        P_TAG, P_LENGTH, P_DELTA, P_STATUS, P_DATA1, P_DATA2,
        P_SYSEX_LEN, P_META_TYPE, P_META_LEN, P_PAYLOAD
    } t_phase;

    // ------------------------------------------------------------------------
    // Parser model and store of expected output transfers
    // ------------------------------------------------------------------------
    class event_scoreboard;
        localparam logic [31:0] TRACK_TAG = 32'h4D54726B;  // "MTrk"
        localparam int VLQ_LIMIT = VLQ_MAX_BYTES_DEF;
        localparam int LEN_ANY = -1;
        localparam int LEN_UNKNOWN = -2;

        t_phase      phase;
        logic [2:0]  byte_cnt;
        logic [27:0] vlq_acc;
        logic [7:0]  prev_status;
        logic [7:0]  cur_status;
        logic [7:0]  held_data;
        logic [7:0]  held_meta;
        logic [27:0] held_delta;
        logic [27:0] remaining;
        bit          halted;

        t_result expected_items[$];
        int mismatches, checked;
        int records, payloads, errors, track_ends;

        function new();
            clear_state();
        endfunction

        // Fixed payload length per meta type, or LEN_ANY / LEN_UNKNOWN
        static function int meta_len(logic [7:0] t);
            case (t)
                8'h00: return 2;
                8'h01, 8'h02, 8'h03, 8'h04,
                8'h05, 8'h06, 8'h07, 8'h7F: return LEN_ANY;
                8'h20, 8'h21: return 1;
                8'h2F: return 0;
                8'h51: return 3;
                8'h54: return 5;
                8'h58: return 4;
                8'h59: return 2;
                default: return LEN_UNKNOWN;
            endcase
        endfunction

        function void clear_state();
            phase = P_TAG;
            byte_cnt = '0;
            vlq_acc = '0;
            prev_status = '0;
            cur_status = '0;
            held_data = '0;
            held_meta = '0;
            held_delta = '0;
            remaining = '0;
            halted = 1'b0;
        endfunction

        // One variable-length byte; 1 when the number is complete
        function bit vlq_take(logic [7:0] b);
            vlq_acc = ((byte_cnt == 0 ? 28'd0 : vlq_acc) << 7) | 28'(b[6:0]);
            byte_cnt = byte_cnt + 3'd1;
            if (!b[7] || byte_cnt >= VLQ_LIMIT) begin
                byte_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_record(logic [7:0] d1, logic [7:0] d2, logic [7:0] meta,
                                  logic [27:0] plen, bit ends);
            t_result r;
            r = '0;
            r.kind = KIND_RECORD;
            r.delta_ticks = held_delta;
            r.status_byte = cur_status;
            r.first_data = d1;
            r.second_data = d2;
            r.meta_kind = meta;
            r.payload_length = plen;
            r.last = (plen == 0);
            r.track_end = ends;
            expected_items.push_back(r);
        endfunction

        function void push_error(t_err code);
            t_result r;
            r = '0;
            r.kind = KIND_ERROR;
            r.last = 1'b1;
            r.error_code = code;
            halted = 1'b1;
            expected_items.push_back(r);
        endfunction

        // Steps the model by one accepted byte; returns 1 if the byte was ignored
        function bit note_byte(logic [7:0] b, logic rs);
            logic [7:0] st;
            bit running;
            int want;
            t_result r;
            if (rs)
                clear_state();
            if (halted)
                return 1'b1;
            case (phase)
                P_TAG: begin
                    if (b != TRACK_TAG[31 - 8 * byte_cnt[1:0] -: 8]) begin
                        push_error(ERR_BAD_TAG);
                    end else begin
                        byte_cnt = byte_cnt + 3'd1;
                        if (byte_cnt >= TAG_LEN) begin
                            byte_cnt = '0;
                            phase = P_LENGTH;
                        end
                    end
                end
                P_LENGTH: begin
                    byte_cnt = byte_cnt + 3'd1;
                    if (byte_cnt >= TAG_LEN) begin
                        byte_cnt = '0;
                        phase = P_DELTA;
                    end
                end
                P_DELTA: begin
                    if (vlq_take(b)) begin
                        held_delta = vlq_acc;
                        phase = P_STATUS;
                    end
                end
                P_STATUS: begin
                    // a data byte here means running status
                    running = !b[7];
                    st = running ? prev_status : b;
                    cur_status = st;
                    if (st[7:4] < 4'h8) begin
                        push_error(ERR_BAD_STATUS);
                    end else if (st[7:4] == STATUS_HI_SYSTEM) begin
                        prev_status = '0;
                        if (st == STATUS_SYSEX) begin
                            phase = P_SYSEX_LEN;
                        end else if (st == STATUS_META) begin
                            phase = P_META_TYPE;
                        end else begin
                            phase = P_DELTA;
                            push_record('0, '0, '0, '0, 1'b0);
                        end
                    end else begin
                        prev_status = st;
                        if (!running) begin
                            phase = P_DATA1;
                        end else begin
                            held_data = b;
                            if (st[7:4] != STATUS_HI_PROGRAM && st[7:4] != STATUS_HI_CHANPRS) begin
                                phase = P_DATA2;
                            end else begin
                                phase = P_DELTA;
                                push_record(b, '0, '0, '0, 1'b0);
                            end
                        end
                    end
                end
                P_DATA1: begin
                    held_data = b;
                    if (cur_status[7:4] != STATUS_HI_PROGRAM &&
                        cur_status[7:4] != STATUS_HI_CHANPRS) begin
                        phase = P_DATA2;
                    end else begin
                        phase = P_DELTA;
                        push_record(b, '0, '0, '0, 1'b0);
                    end
                end
                P_DATA2: begin
                    phase = P_DELTA;
                    push_record(held_data, b, '0, '0, 1'b0);
                end
                P_SYSEX_LEN: begin
                    remaining = 28'(b);
                    phase = (b != 0) ? P_PAYLOAD : P_DELTA;
                    push_record('0, '0, '0, 28'(b), 1'b0);
                end
                P_META_TYPE: begin
                    held_meta = b;
                    if (meta_len(b) == LEN_UNKNOWN) begin
                        push_error(ERR_UNKNOWN_META);
                    end else begin
                        byte_cnt = '0;
                        phase = P_META_LEN;
                    end
                end
                P_META_LEN: begin
                    if (vlq_take(b)) begin
                        want = meta_len(held_meta);
                        if (want >= 0 && vlq_acc != 28'(want)) begin
                            push_error(ERR_META_LENGTH);
                        end else begin
                            remaining = vlq_acc;
                            if (held_meta == META_END_OF_TRACK) begin
                                phase = P_TAG;
                                byte_cnt = '0;
                                push_record('0, '0, held_meta, '0, 1'b1);
                            end else begin
                                phase = (vlq_acc != 0) ? P_PAYLOAD : P_DELTA;
                                push_record('0, '0, held_meta, vlq_acc, 1'b0);
                            end
                        end
                    end
                end
                P_PAYLOAD: begin
                    remaining = remaining - 28'd1;
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.last = (remaining == 0);
                    expected_items.push_back(r);
                    if (remaining == 0)
                        phase = P_DELTA;
                end
                default: begin
                    phase = P_TAG;
                    byte_cnt = '0;
                end
            endcase
            return 1'b0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        endtask

        // Compares one output transfer with the oldest expectation
        task check_item(t_result got, logic [OUT_DATA_W-100:0] pad);
            t_result want;
            string tag;
            if (expected_items.size() == 0) begin
                report($sformatf("unexpected transfer, kind %0d", got.kind));
            end else begin
                want = expected_items.pop_front();
                checked++;
                tag = $sformatf("item %0d:", checked);
                case (want.kind)
                    KIND_RECORD: begin
                        records++;
                        if (want.track_end)
                            track_ends++;
                    end
                    KIND_PAYLOAD: payloads++;
                    default: errors++;
                endcase
                if (got.kind !== want.kind)
                    report($sformatf("%s kind exp %0d got %0d", tag, want.kind, got.kind));
                if (got.delta_ticks !== want.delta_ticks)
                    report($sformatf("%s delta_ticks exp %0h got %0h", tag,
                                     want.delta_ticks, got.delta_ticks));
                if (got.status_byte !== want.status_byte)
                    report($sformatf("%s status_byte exp %0h got %0h", tag,
                                     want.status_byte, got.status_byte));
                if (got.first_data !== want.first_data)
                    report($sformatf("%s first_data exp %0h got %0h", tag,
                                     want.first_data, got.first_data));
                if (got.second_data !== want.second_data)
                    report($sformatf("%s second_data exp %0h got %0h", tag,
                                     want.second_data, got.second_data));
                if (got.meta_kind !== want.meta_kind)
                    report($sformatf("%s meta_kind exp %0h got %0h", tag,
                                     want.meta_kind, got.meta_kind));
                if (got.payload_length !== want.payload_length)
                    report($sformatf("%s payload_length exp %0d got %0d", tag,
                                     want.payload_length, got.payload_length));
                if (got.payload_byte !== want.payload_byte)
                    report($sformatf("%s payload_byte exp %0h got %0h", tag,
                                     want.payload_byte, got.payload_byte));
                if (got.last !== want.last)
                    report($sformatf("%s last exp %0b got %0b", tag, want.last, got.last));
                if (got.error_code !== want.error_code)
                    report($sformatf("%s error_code exp %0d got %0d", tag,
                                     want.error_code, got.error_code));
                if (got.track_end !== want.track_end)
                    report($sformatf("%s track_end exp %0b got %0b", tag,
                                     want.track_end, got.track_end));
                if (pad !== '0)
                    report($sformatf("%s tdata padding not zero: %0h", tag, pad));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] in_byte
    logic                  s_axis_tuser = 1'b0; // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // record, payload and error fields
    logic [1:0]            m_axis_tuser;        // [1:0] kind
    logic                  m_axis_tlast;

    event_scoreboard sb = new();
    int  live_items = 0;    // accepted bytes the parser did not ignore
    int  quiet_cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    bit  running_ok;        // running status in effect on the generator side
    logic [7:0] gen_status;
    bit  clean_end = 1'b0;  // last track closed by end of track

    always #4 i_clk = ~i_clk;

    midi_track_event_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic int idle_draw(bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Mostly 7-bit data, sometimes with bit 7 set
    function automatic logic [7:0] rand_data();
        return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic rs = 1'b0);
        int gap;
        gap = idle_draw(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= rs;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        if (!sb.note_byte(b, rs))
            live_items++;
    endtask

    // Big-endian variable-length number in exactly n bytes
    task automatic send_vlq(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(8'((v >> (7 * i)) & 32'h7F) | (i > 0 ? 8'h80 : 8'h00));
    endtask

    task automatic send_payload(int n);
        repeat (n) send_byte(8'($urandom));
    endtask

    // One event with its delta; broke is set when it ends in an error
    task automatic send_event(output bit broke);
        int pick, n, len;
        logic [7:0] st, t;
        broke = 1'b0;

        // delta time, now and then overlong with the continuation bit left on
        if ($urandom_range(0, 11) == 0) begin
            repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)));
        end else begin
            n = $urandom_range(1, 4);
            send_vlq($urandom & ((32'd1 << (7 * n)) - 1), n);
        end

        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // channel message, explicit or running status
            if (running_ok && $urandom_range(0, 2) == 0) begin
                send_byte(8'($urandom_range(0, 127)));
            end else begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                gen_status = st;
                running_ok = 1'b1;
                send_byte(st);
                send_byte(rand_data());
            end
            if (gen_status[7:4] != STATUS_HI_PROGRAM && gen_status[7:4] != STATUS_HI_CHANPRS)
                send_byte(rand_data());
        end else if (pick < 55) begin
            // other system status, record only
            send_byte(8'($urandom_range(8'hF1, 8'hFE)));
            running_ok = 1'b0;
        end else if (pick < 67) begin
            send_byte(STATUS_SYSEX);
            running_ok = 1'b0;
            case ($urandom_range(0, 19))
                0:       len = 255;
                1, 2, 3: len = $urandom_range(7, 40);
                default: len = $urandom_range(0, 6);
            endcase
            send_byte(8'(len));
            send_payload(len);
        end else if (pick < 90) begin
            send_byte(STATUS_META);
            running_ok = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                case ($urandom_range(0, 6))
                    0: t = 8'h00;
                    1: t = 8'h20;
                    2: t = 8'h21;
                    3: t = 8'h51;
                    4: t = 8'h54;
                    5: t = 8'h58;
                    default: t = 8'h59;
                endcase
                len = event_scoreboard::meta_len(t);
                send_byte(t);
                send_vlq(len, $urandom_range(1, 2));
            end else if (pick < 9) begin
                t = ($urandom_range(0, 7) == 7) ? 8'h7F : 8'($urandom_range(1, 7));
                len = $urandom_range(0, 8);
                send_byte(t);
                send_vlq(len, $urandom_range(1, 3));
            end else begin
                // length cut off after four bytes with continuation set
                t = META_TEMPO;
                len = 3;
                send_byte(t);
                send_byte(8'h80);
                send_byte(8'h80);
                send_byte(8'h80);
                send_byte(8'h83);
            end
            send_payload(len);
        end else if (pick < 94) begin
            // data byte with no running status in effect
            send_byte(STATUS_TUNE_REQ);
            running_ok = 1'b0;
            send_vlq($urandom_range(0, 127), 1);
            send_byte(8'($urandom_range(0, 127)));
            broke = 1'b1;
        end else if (pick < 97) begin
            send_byte(STATUS_META);
            do t = 8'($urandom); while (event_scoreboard::meta_len(t) != event_scoreboard::LEN_UNKNOWN);
            send_byte(t);
            broke = 1'b1;
        end else begin
            // fixed-length meta type with the wrong length
            send_byte(STATUS_META);
            case ($urandom_range(0, 7))
                0: t = 8'h00;
                1: t = 8'h20;
                2: t = 8'h21;
                3: t = 8'h51;
                4: t = 8'h54;
                5: t = 8'h58;
                6: t = 8'h59;
                default: t = META_END_OF_TRACK;
            endcase
            send_byte(t);
            send_vlq(event_scoreboard::meta_len(t) + $urandom_range(1, 3), 1);
            broke = 1'b1;
        end
    endtask

    // Chunk header, a few events and usually an end of track
    task automatic run_track();
        bit rs, broke;
        int n_ev, pos;
        logic [7:0] b;
        tx_calm = ($urandom_range(0, 3) == 0);
        rs = !clean_end || ($urandom_range(0, 1) == 1);
        running_ok = 1'b0;
        broke = 1'b0;
        pos = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : -1;
        for (int i = 0; i < 4 && !broke; i++) begin
            b = event_scoreboard::TRACK_TAG[31 - 8 * i -: 8];
            if (i == pos) begin
                b = b ^ 8'($urandom_range(1, 255));
                broke = 1'b1;
            end
            send_byte(b, (i == 0) ? rs : 1'b0);
        end
        if (!broke)
            repeat (4) send_byte(8'($urandom));
        n_ev = $urandom_range(1, 10);
        while (!broke && n_ev > 0) begin
            send_event(broke);
            n_ev--;
        end
        if (broke) begin
            // stray bytes while halted
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            clean_end = 1'b0;
        end else if ($urandom_range(0, 9) != 0) begin
            send_vlq($urandom_range(0, 300), 2);
            send_byte(STATUS_META);
            send_byte(META_END_OF_TRACK);
            send_byte(8'h00);
            clean_end = 1'b1;
        end else begin
            // abandoned mid-track
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            clean_end = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, then check every transfer
    // ------------------------------------------------------------------------
    initial begin
        int stall, served;
        served = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_draw(rx_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            served++;
            if (served % 40 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = t_kind'(m_axis_tuser);
            got.delta_ticks = m_axis_tdata[27:0];
            got.status_byte = m_axis_tdata[35:28];
            got.first_data = m_axis_tdata[43:36];
            got.second_data = m_axis_tdata[51:44];
            got.meta_kind = m_axis_tdata[59:52];
            got.payload_length = m_axis_tdata[87:60];
            got.payload_byte = m_axis_tdata[95:88];
            got.error_code = t_err'(m_axis_tdata[97:96]);
            got.track_end = m_axis_tdata[98];
            got.last = m_axis_tlast;
            sb.check_item(got, m_axis_tdata[OUT_DATA_W-1:99]);
        end
    end

    // Watchdog on transfer activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, sb.expected_items.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] intro[$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed track: longest delta, program change with a high data byte,
        // running status, empty SysEx and end of track
        intro = '{8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h17,
                  8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'hFF,
                  8'h00, 8'h12,
                  8'h00, STATUS_SYSEX, 8'h00,
                  8'h00, STATUS_META, META_END_OF_TRACK, 8'h00};
        foreach (intro[i])
            send_byte(intro[i], i == 0);
        // restart on a wrong tag byte, then a byte that is ignored
        send_byte(8'h00, 1'b1);
        send_byte(8'h4D);
        clean_end = 1'b0;

        while (live_items < TARGET_ITEMS)
            run_track();
        s_axis_tvalid <= 1'b0;

        while (sb.expected_items.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Parsed %0d bytes into %0d checked transfers: %0d event records,",
                 live_items, sb.checked, sb.records);
        $display("%0d payload bytes, %0d errors, %0d track ends; %0d mismatches.",
                 sb.payloads, sb.errors, sb.track_ends, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mtep_pkg.sv
rtl/core/mtep_in_reg.sv
rtl/core/mtep_decoder.sv
rtl/core/mtep_out_reg.sv
rtl/core/midi_track_event_parser.sv
rtl/core/mtep_checker.sv
tb/testbench.sv
